// ===== hdl/hpmd_pkg.sv =====
// Shared widths, constants and types for the heading PI motor drive.
package hpmd_pkg;

    // Field and register widths
    localparam int HEAD_W        = 16;
    localparam int TOL_W         = 15;
    localparam int GAIN_W        = 12;
    localparam int PER_W         = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int PCT_W         = 8;

    // Internal datapath widths
    localparam int ERR_W         = HEAD_W + 2;          // signed wrap candidates
    localparam int EMAG_W        = ERR_W - 1;           // error magnitude
    localparam int INC_W         = EMAG_W + PER_W;      // |error| * period
    localparam int P_W           = EMAG_W + GAIN_W;     // |error| * kp
    localparam int PS_W          = P_W + 10;            // |error| * kp * 1000
    localparam int ITERM_W       = 41;                  // integral term, saturated at 2^40
    localparam int V_W           = ITERM_W + 2;         // signed controller sum
    localparam int CLAMP_W       = 33;                  // clamped magnitude
    localparam int QUOT_W        = 7;                   // percent magnitude 0..100

    localparam int ACC_WIDTH_DEF = 48;

    // Arithmetic constants
    localparam logic [ERR_W-1:0]   WRAP_FULL  = 18'd36000;
    localparam logic [ITERM_W-1:0] TERM_LIMIT = 41'h100_0000_0000;
    localparam logic [CLAMP_W-1:0] OUT_CLAMP  = 33'd6502400000;
    localparam logic [CLAMP_W-1:0] PCT_DIV    = 33'd65024000;

    // Register reset values
    localparam logic [HEAD_W-1:0] TARGET_RST = 16'd12000;
    localparam logic [TOL_W-1:0]  TOL_RST    = 15'd150;
    localparam logic [GAIN_W-1:0] KP_RST     = 12'd282;
    localparam logic [GAIN_W-1:0] KI_RST     = 12'd282;
    localparam logic [PER_W-1:0]  PERIOD_RST = 10'd60;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 3'd0,
        REG_TOL    = 3'd1,
        REG_KP     = 3'd2,
        REG_KI     = 3'd3,
        REG_PERIOD = 3'd4
    } cfg_reg_t;

    // Wrapped heading error
    typedef struct packed {
        logic              near;   // |error| below tolerance
        logic              neg;    // error sign
        logic [EMAG_W-1:0] mag;    // error magnitude
    } err_t;

endpackage

// ===== hdl/hpmd_wrap.sv =====
// Shortest signed heading error with compass wrap and tolerance check.
module hpmd_wrap
    import hpmd_pkg::*;
(
    input  logic [HEAD_W-1:0] target,
    input  logic [HEAD_W-1:0] heading,
    input  logic [TOL_W-1:0]  tol,
    output err_t              err
);

    logic signed [ERR_W-1:0] e1;
    logic signed [ERR_W-1:0] e2;
    logic signed [ERR_W-1:0] e3;
    logic [EMAG_W-1:0]       a1;
    logic [EMAG_W-1:0]       a2;
    logic [EMAG_W-1:0]       a3;
    logic signed [ERR_W-1:0] esel;
    logic [EMAG_W-1:0]       asel;

    function automatic logic [EMAG_W-1:0] mag_of(input logic signed [ERR_W-1:0] v);
        logic [ERR_W-1:0] t;
        t = v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
        return t[EMAG_W-1:0];
    endfunction

    // Form the direct, +full-turn and -full-turn candidates
    always_comb
    begin
        e1 = $signed(ERR_W'(target)) - $signed(ERR_W'(heading));
        e2 = e1 + $signed(WRAP_FULL);
        e3 = e1 - $signed(WRAP_FULL);
        a1 = mag_of(e1);
        a2 = mag_of(e2);
        a3 = mag_of(e3);
    end

    // Pick the smallest magnitude; ties go to direct, then +full-turn
    always_comb
    begin
        if (a1 <= a2 && a1 <= a3)
        begin
            esel = e1;
            asel = a1;
        end
        else if (a2 <= a1 && a2 <= a3)
        begin
            esel = e2;
            asel = a2;
        end
        else
        begin
            esel = e3;
            asel = a3;
        end
        err.neg  = esel[ERR_W-1];
        err.mag  = asel;
        err.near = (asel < EMAG_W'(tol));
    end

endmodule

// ===== hdl/hpmd_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module hpmd_mul
    import hpmd_pkg::*;
#(
    parameter int A_W = 16,
    parameter int B_W = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic             busy,
    output logic [A_W+B_W-1:0] prod
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [A_W-1:0]   a_reg;
    logic [A_W-1:0]   hi_reg;
    logic [B_W-1:0]   lo_reg;
    logic [A_W:0]     sum;

    // Add the multiplicand when the current multiplier bit is set
    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
    assign busy = (cnt_reg != '0);
    assign prod = {hi_reg, lo_reg};

    // Count the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(B_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Load operands, then shift the partial product right each step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy)
        begin
            hi_reg <= sum[A_W:1];
            lo_reg <= {sum[0], lo_reg[B_W-1:1]};
        end
    end

endmodule

// ===== hdl/hpmd_div.sv =====
// Restoring divider by the percent step, one quotient bit per cycle.
module hpmd_div
    import hpmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CLAMP_W-1:0] dividend,
    output logic               busy,
    output logic [QUOT_W-1:0]  quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic [CLAMP_W-1:0] rem_reg;
    logic [CLAMP_W-1:0] dsh_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic               fits;

    assign fits = (rem_reg >= dsh_reg);
    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

    // Count the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(QUOT_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Subtract the shifted divisor where it fits, shift in a quotient bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= PCT_DIV << (QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (busy)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

endmodule

// ===== hdl/heading_pi_motor_drive.sv =====
// Heading PI motor drive top level: control sequencer, integral and output register.
//
//   channel   direction  handshake               payload
//   heading   in         heading_valid / _stall  heading
//   result    out        result_valid / _stall   drive_percent, on_target
//   cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An off-target sample runs two bit-serial multiplies side by side, then a 12-step
// bit-serial multiply and a 7-step divider. An on-target sample skips all of them.
// One sample is processed at a time.
// Reset restores the register defaults and clears the integral and the result register.
// A stalled result holds in its register; a new sample is taken meanwhile, and its
// result waits in the last step until the register frees.
module heading_pi_motor_drive
    import hpmd_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    heading_valid,
    output logic                    heading_stall,
    input  logic [HEAD_W-1:0]       heading,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [PCT_W-1:0] drive_percent,
    output logic                    on_target,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int IPROD_W = ACC_WIDTH + GAIN_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_MUL1,
        ST_INTEG,
        ST_IMAG,
        ST_MUL2,
        ST_SUM,
        ST_CLAMP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [HEAD_W-1:0] target_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [PER_W-1:0]  period_reg;

    // Datapath registers
    logic [HEAD_W-1:0]          heading_reg;
    logic                       e_neg_reg;
    logic                       near_reg;
    logic [PS_W-1:0]            p_scaled_reg;
    logic                       i_neg_reg;
    logic signed [V_W-1:0]      v_reg;
    logic                       v_neg_reg;
    logic signed [ACC_WIDTH-1:0] integral_reg;
    logic signed [ACC_WIDTH-1:0] integral_next;

    // Result register
    logic                    result_valid_reg;
    logic signed [PCT_W-1:0] drive_reg;
    logic                    on_target_reg;

    // Unit hookup
    err_t                err;
    logic                mul1_start;
    logic                inc_busy;
    logic                p_busy;
    logic [INC_W-1:0]    prod_inc;
    logic [P_W-1:0]      prod_p;
    logic                mul_i_start;
    logic                i_busy;
    logic [ACC_WIDTH-1:0] imag;
    logic [IPROD_W-1:0]  prod_i;
    logic                div_start;
    logic                div_busy;
    logic [CLAMP_W-1:0]  vmag_clamped;
    logic [QUOT_W-1:0]   quot;

    logic                       accept;
    logic signed [ACC_WIDTH:0]  inc_ext;
    logic signed [ACC_WIDTH:0]  acc_sum;
    logic [ITERM_W-1:0]         iterm_mag;
    logic signed [V_W-1:0]      p_signed;
    logic signed [V_W-1:0]      i_signed;
    logic [V_W-1:0]             vmag;
    logic signed [PCT_W-1:0]    drive_next;

    assign accept        = heading_valid && !heading_stall;
    assign heading_stall = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_valid  = result_valid_reg;
    assign drive_percent = drive_reg;
    assign on_target     = on_target_reg;

    assign mul1_start  = (state_reg == ST_WRAP) && !err.near;
    assign mul_i_start = (state_reg == ST_IMAG);
    assign div_start   = (state_reg == ST_CLAMP);

    hpmd_wrap u_wrap (
        .target  (target_reg),
        .heading (heading_reg),
        .tol     (tol_reg),
        .err     (err)
    );

    hpmd_mul #(
        .A_W (EMAG_W),
        .B_W (PER_W)
    ) u_mul_inc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul1_start),
        .a     (err.mag),
        .b     (period_reg),
        .busy  (inc_busy),
        .prod  (prod_inc)
    );

    hpmd_mul #(
        .A_W (EMAG_W),
        .B_W (GAIN_W)
    ) u_mul_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul1_start),
        .a     (err.mag),
        .b     (kp_reg),
        .busy  (p_busy),
        .prod  (prod_p)
    );

    hpmd_mul #(
        .A_W (ACC_WIDTH),
        .B_W (GAIN_W)
    ) u_mul_i (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_i_start),
        .a     (imag),
        .b     (ki_reg),
        .busy  (i_busy),
        .prod  (prod_i)
    );

    hpmd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vmag_clamped),
        .busy     (div_busy),
        .quot     (quot)
    );

    // Saturating integral update
    always_comb
    begin
        inc_ext = e_neg_reg ? -$signed((ACC_WIDTH+1)'(prod_inc))
                            : $signed((ACC_WIDTH+1)'(prod_inc));
        acc_sum = {integral_reg[ACC_WIDTH-1], integral_reg} + inc_ext;
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1])
        begin
            integral_next = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                               : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        else
        begin
            integral_next = acc_sum[ACC_WIDTH-1:0];
        end
    end

    // Integral magnitude for the integral-term multiply
    assign imag = integral_reg[ACC_WIDTH-1] ? ACC_WIDTH'(-integral_reg)
                                            : ACC_WIDTH'(integral_reg);

    // Saturate the integral term and form the signed controller sum
    always_comb
    begin
        iterm_mag = (prod_i > IPROD_W'(TERM_LIMIT)) ? TERM_LIMIT : prod_i[ITERM_W-1:0];
        p_signed  = e_neg_reg ? -$signed(V_W'(p_scaled_reg)) : $signed(V_W'(p_scaled_reg));
        i_signed  = i_neg_reg ? -$signed(V_W'(iterm_mag)) : $signed(V_W'(iterm_mag));
    end

    // Magnitude of the sum, clamped to the full-scale output
    always_comb
    begin
        vmag = v_reg[V_W-1] ? V_W'(-v_reg) : V_W'(v_reg);
        vmag_clamped = (vmag > V_W'(OUT_CLAMP)) ? OUT_CLAMP : vmag[CLAMP_W-1:0];
    end

    // Apply the sign to the percent, or zero when on target
    always_comb
    begin
        if (near_reg)
        begin
            drive_next = '0;
        end
        else if (v_neg_reg)
        begin
            drive_next = -$signed({1'b0, quot});
        end
        else
        begin
            drive_next = $signed({1'b0, quot});
        end
    end

    // Sequence one sample through the units
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_WRAP;
            ST_WRAP:   state_next = err.near ? ST_FINISH : ST_MUL1;
            ST_MUL1:   if (!inc_busy && !p_busy) state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_IMAG;
            ST_IMAG:   state_next = ST_MUL2;
            ST_MUL2:   if (!i_busy) state_next = ST_SUM;
            ST_SUM:    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_DIV;
            ST_DIV:    if (!div_busy) state_next = ST_FINISH;
            ST_FINISH: if (!result_valid_reg || !result_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Hold state, integral and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            integral_reg     <= '0;
            result_valid_reg <= 1'b0;
            drive_reg        <= '0;
            on_target_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INTEG)
            begin
                integral_reg <= integral_next;
            end
            // Load a finished result, or drop the register once it is taken
            if (state_reg == ST_FINISH && (!result_valid_reg || !result_stall))
            begin
                result_valid_reg <= 1'b1;
                drive_reg        <= drive_next;
                on_target_reg    <= near_reg;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Capture operands and intermediate results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            heading_reg <= heading;
        end
        if (state_reg == ST_WRAP)
        begin
            e_neg_reg <= err.neg;
            near_reg  <= err.near;
        end
        if (state_reg == ST_INTEG)
        begin
            // times 1000 as 1024 - 16 - 8
            p_scaled_reg <= (PS_W'(prod_p) << 10) - (PS_W'(prod_p) << 4)
                          - (PS_W'(prod_p) << 3);
        end
        if (state_reg == ST_IMAG)
        begin
            i_neg_reg <= integral_reg[ACC_WIDTH-1];
        end
        if (state_reg == ST_SUM)
        begin
            v_reg <= p_signed + i_signed;
        end
        if (state_reg == ST_CLAMP)
        begin
            v_neg_reg <= v_reg[V_W-1];
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RST;
            tol_reg    <= TOL_RST;
            kp_reg     <= KP_RST;
            ki_reg     <= KI_RST;
            period_reg <= PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET: target_reg <= cfg_data[HEAD_W-1:0];
                REG_TOL:    tol_reg    <= cfg_data[TOL_W-1:0];
                REG_KP:     kp_reg     <= cfg_data[GAIN_W-1:0];
                REG_KI:     ki_reg     <= cfg_data[GAIN_W-1:0];
                REG_PERIOD: period_reg <= cfg_data[PER_W-1:0];
                default:    ;
            endcase
        end
    end

    // An on-target result always carries zero drive
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && on_target |-> drive_percent == '0)
        else $error("on-target result with nonzero drive");

    // Drive stays within full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (drive_percent <= 8'sd100 && drive_percent >= -8'sd100))
        else $error("drive percent out of range");

    // An accepted sample blocks the next one while it is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        heading_valid && !heading_stall |=> heading_stall)
        else $error("second sample taken before the first was processed");

    // The integral moves only in its update step
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(integral_reg) |-> $past(state_reg) == ST_INTEG)
        else $error("integral changed outside its update step");

endmodule

// ===== test/tb_heading_pi_motor_drive.sv =====
// Self-checking testbench for the heading PI motor drive, with its scoreboard.
`timescale 1ns / 1ps

module tb_heading_pi_motor_drive;
    import hpmd_pkg::*;

    localparam int     ITEMS_PER_PHASE = 450;
    localparam int     STALL_LIMIT     = 4000;
    localparam int     TAIL_CYCLES     = 60;
    localparam int     HEADING_SPAN    = 36000;
    localparam longint DRIVE_CLAMP     = 64'sd6502400000;
    localparam longint PERCENT_DIV     = 64'sd65024000;
    localparam longint P_SCALE         = 64'sd1000;
    localparam longint ITERM_LIMIT     = 64'sd1 << 40;
    localparam longint INTEG_MAX       = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 64'sd1;
    localparam longint INTEG_MIN       = -INTEG_MAX - 64'sd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_PERIOD + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic signed [PCT_W-1:0] pct;
        logic                    tgt_flag;
    } drive_result_t;

    // Scoreboard: controller state, settings and the drive results still owed
    class drive_scoreboard;
        logic [HEAD_W-1:0] target;
        logic [TOL_W-1:0]  tol;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [PER_W-1:0]  period;
        longint            integral;
        drive_result_t     expected_drive[$];
        int                errors;

        function new();
            target   = TARGET_RST;
            tol      = TOL_RST;
            kp       = KP_RST;
            ki       = KI_RST;
            period   = PERIOD_RST;
            integral = 0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET: target = data[HEAD_W-1:0];
                REG_TOL:    tol    = data[TOL_W-1:0];
                REG_KP:     kp     = data[GAIN_W-1:0];
                REG_KI:     ki     = data[GAIN_W-1:0];
                REG_PERIOD: period = data[PER_W-1:0];
                default:    ;
            endcase
        endfunction

        function longint mag_of(input longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Predict the drive for one heading sample and advance the integral
        function void predict_drive(input logic [HEAD_W-1:0] h);
            longint          t_l, h_l, e1, e2, e3, err, inc, v, pct;
            longint          p_l, kp_l, ki_l;
            longint unsigned mag, prod;
            drive_result_t   r;
            t_l  = target;
            h_l  = h;
            p_l  = period;
            kp_l = kp;
            ki_l = ki;
            e1   = t_l - h_l;
            e2   = e1 + HEADING_SPAN;
            e3   = e1 - HEADING_SPAN;
            // Shortest way round; ties keep the direct form, then the +360 form
            if (mag_of(e1) <= mag_of(e2) && mag_of(e1) <= mag_of(e3))
                err = e1;
            else if (mag_of(e2) <= mag_of(e3))
                err = e2;
            else
                err = e3;

            if (mag_of(err) < longint'(tol))
            begin
                r.pct      = '0;
                r.tgt_flag = 1'b1;
                expected_drive.push_back(r);
                return;
            end

            // Saturating integration
            inc = err * p_l;
            if (inc > 0 && integral > INTEG_MAX - inc)
                integral = INTEG_MAX;
            else if (inc < 0 && integral < INTEG_MIN - inc)
                integral = INTEG_MIN;
            else
                integral = integral + inc;

            // Integral term, saturated in magnitude
            prod = 0;
            if (ki_l != 0 && integral != 0)
            begin
                mag = (integral < 0) ? -integral : integral;
                if (mag > ITERM_LIMIT / ki_l)
                    prod = ITERM_LIMIT;
                else
                    prod = mag * ki_l;
            end
            v = err * kp_l * P_SCALE + ((integral < 0) ? -longint'(prod) : longint'(prod));
            if (v > DRIVE_CLAMP)
                v = DRIVE_CLAMP;
            else if (v < -DRIVE_CLAMP)
                v = -DRIVE_CLAMP;
            pct        = v / PERCENT_DIV;
            r.pct      = PCT_W'(pct);
            r.tgt_flag = 1'b0;
            expected_drive.push_back(r);
        endfunction

        task report(input string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(input logic signed [PCT_W-1:0] pct, input logic tgt_flag);
            drive_result_t want;
            if (expected_drive.size() == 0)
            begin
                report($sformatf("result with none owed: drive=%0d on_target=%0b",
                                 pct, tgt_flag));
                return;
            end
            want = expected_drive.pop_front();
            if (pct !== want.pct)
                report($sformatf("drive_percent %0d, want %0d", pct, want.pct));
            if (tgt_flag !== want.tgt_flag)
                report($sformatf("on_target %0b, want %0b", tgt_flag, want.tgt_flag));
        endtask
    endclass

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    heading_valid = 1'b0;
    logic                    heading_stall;
    logic [HEAD_W-1:0]       heading       = '0;
    logic                    result_valid;
    logic                    result_stall  = 1'b0;
    logic signed [PCT_W-1:0] drive_percent;
    logic                    on_target;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index     = REG_TARGET;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    drive_scoreboard sb = new();
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              quiet_cycles   = 0;

    heading_pi_motor_drive dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .heading_valid (heading_valid),
        .heading_stall (heading_stall),
        .heading       (heading),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .drive_percent (drive_percent),
        .on_target     (on_target),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the result channel at random
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Observe every transaction on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(drive_percent, on_target);
            if (heading_valid && !heading_stall)
                sb.predict_drive(heading);
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
        end
    end

    // Watchdog: end the run when no transaction happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((result_valid && !result_stall) || (heading_valid && !heading_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Send one heading, with random idle cycles ahead of it
    task automatic push_heading(input logic [HEAD_W-1:0] h);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            heading_valid <= 1'b0;
            @(posedge clk);
        end
        heading_valid <= 1'b1;
        heading       <= h;
        do @(posedge clk); while (heading_stall);
    endtask

    // Hold the sender until every owed result has come back
    task automatic drain_results();
        heading_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Load all five registers plus one unmapped index, then drop valid
    task automatic load_settings(input logic [CFG_DATA_W-1:0] tgt_d,
                                 input logic [CFG_DATA_W-1:0] tol_d,
                                 input logic [CFG_DATA_W-1:0] kp_d,
                                 input logic [CFG_DATA_W-1:0] ki_d,
                                 input logic [CFG_DATA_W-1:0] per_d);
        write_cfg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                  CFG_DATA_W'($urandom));
        write_cfg(REG_TARGET, tgt_d);
        write_cfg(REG_TOL, tol_d);
        write_cfg(REG_KP, kp_d);
        write_cfg(REG_KI, ki_d);
        write_cfg(REG_PERIOD, per_d);
        cfg_valid <= 1'b0;
    endtask

    // Pick new settings, biased toward small integral gain and period
    task automatic load_random_settings();
        logic [CFG_DATA_W-1:0] raw;
        logic [CFG_DATA_W-1:0] tgt_d, tol_d, kp_d, ki_d, per_d;
        raw = CFG_DATA_W'($urandom);
        case ($urandom_range(9, 0))
            0:       tgt_d = '0;
            1:       tgt_d = 16'd35999;
            2:       tgt_d = CFG_DATA_W'($urandom_range(65535, 36000));
            default: tgt_d = CFG_DATA_W'($urandom_range(35999, 0));
        endcase
        case ($urandom_range(9, 0))
            0:       tol_d = '0;
            1:       tol_d = 16'd18000;
            2:       tol_d = 16'd32767;
            3:       tol_d = CFG_DATA_W'($urandom_range(32767, 0));
            default: tol_d = CFG_DATA_W'($urandom_range(2000, 0));
        endcase
        tol_d = tol_d | (raw & 16'h8000);
        kp_d  = CFG_DATA_W'($urandom);
        if ($urandom_range(1, 0) == 0)
            ki_d = (raw & 16'hF000) | CFG_DATA_W'($urandom_range(8, 0));
        else
            ki_d = CFG_DATA_W'($urandom);
        case ($urandom_range(9, 0))
            0:       per_d = '0;
            1:       per_d = 16'd1000;
            2:       per_d = 16'd1023;
            3, 4:    per_d = CFG_DATA_W'($urandom_range(1023, 0));
            default: per_d = CFG_DATA_W'($urandom_range(20, 1));
        endcase
        per_d = per_d | (raw & 16'hFC00);
        load_settings(tgt_d, tol_d, kp_d, ki_d, per_d);
    endtask

    // Mostly headings around the target, some anywhere, some out of range
    function automatic logic [HEAD_W-1:0] pick_heading();
        int pick, span, offs;
        pick = $urandom_range(99, 0);
        if (pick < 15)
            return HEAD_W'($urandom_range(65535, 0));
        if (pick < 45)
            return HEAD_W'($urandom_range(35999, 0));
        span = int'(sb.tol) + 400;
        offs = $urandom_range(2 * span, 0);
        offs = offs - span;
        return HEAD_W'((int'(sb.target) % HEADING_SPAN + offs + 2 * HEADING_SPAN)
                       % HEADING_SPAN);
    endfunction

    initial
    begin
        int sent, burst;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 66 : 0;
            recv_stall_pct = (phase == 0) ? 66 : (phase == 1) ? 27 : 0;

            if (phase == 0)
            begin
                // Reset settings: on-target edge, wrap ties, field extremes
                push_heading(16'd12000);
                push_heading(16'd12149);
                push_heading(16'd12150);
                push_heading(16'd11851);
                push_heading(16'd11850);
                push_heading(16'd30000);
                push_heading(16'd0);
                push_heading(16'd35999);
                push_heading(16'd65535);
                push_heading(16'd48000);
                push_heading(16'd47999);
                drain_results();

                // Zero tolerance, full gains: zero error stays off target
                load_settings(16'd30000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1000);
                push_heading(16'd12000);
                push_heading(16'd30000);
                push_heading(16'd65535);
                push_heading(16'd0);
                push_heading(16'd29999);
                push_heading(16'd30001);
                drain_results();

                // Out-of-range target, masked tolerance, zero period
                load_settings(16'hFFFF, 16'h8000, 16'h0001, 16'h0FFF, 16'hFC00);
                push_heading(16'd0);
                push_heading(16'd65535);
                push_heading(16'd32768);
                push_heading(16'd18000);
            end

            // Random bursts, each under fresh settings loaded while idle
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                drain_results();
                load_random_settings();
                burst = $urandom_range(60, 20);
                repeat (burst) push_heading(pick_heading());
                sent += burst;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
